// ===== rtl/core/dual_quadrature_odometer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual quadrature odometer
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_QUADRATURE_ODOMETER_UNIT_MACROS_SVH
`define DUAL_QUADRATURE_ODOMETER_UNIT_MACROS_SVH

// same-cycle implication
`define QOD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QOD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/qod_pkg.sv =====
// ----------------------------------------------------------------------------
// qod_pkg
// Widths, reset values, codes and types shared by the odometer files.
// ----------------------------------------------------------------------------
package qod_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int LATCH_W         = 16;
  localparam int SCALE_W         = 24;
  localparam int PERIOD_W        = 16;
  localparam int SPEED_W         = 40;
  localparam int DIST_W          = 48;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 24;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = 2;

  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 24'd65536;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd655;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_SCALE   = 1'b0,
    CFG_SAMPLE_PERIOD = 1'b1
  } cfg_idx_t;

  typedef enum logic [4:0] {
    BK_IDLE  = 5'b00001,
    BK_SPEED = 5'b00010,
    BK_STEP  = 5'b00100,
    BK_ACC   = 5'b01000,
    BK_EMIT  = 5'b10000
  } back_state_t;

  // counts latched on one tick
  typedef struct packed {
    logic signed [LATCH_W-1:0] count_one;
    logic signed [LATCH_W-1:0] count_two;
  } tick_entry_t;

  // queue status seen by the front end
  typedef struct packed {
    logic               full;
    logic [QPTR_W:0]    count;
  } queue_status_t;

endpackage

// ===== rtl/core/qod_if.sv =====
// ----------------------------------------------------------------------------
// qod_in_if / qod_out_if
// Valid/ready channels for encoder samples and odometry results.
// ----------------------------------------------------------------------------
interface qod_in_if;
  logic valid;
  logic ready;
  logic line_a;
  logic line_b;
  logic line_c;
  logic line_d;
  logic sample_tick;

  modport source (output valid, line_a, line_b, line_c, line_d, sample_tick,
                  input ready);
  modport sink   (input valid, line_a, line_b, line_c, line_d, sample_tick,
                  output ready);
endinterface

interface qod_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [qod_pkg::SPEED_W-1:0] speed_one;
  logic signed [qod_pkg::SPEED_W-1:0] speed_two;
  logic signed [qod_pkg::DIST_W-1:0]  distance_one;
  logic signed [qod_pkg::DIST_W-1:0]  distance_two;
  logic signed [qod_pkg::DIST_W-1:0]  mean_distance;

  modport source (output valid, speed_one, speed_two, distance_one, distance_two,
                  mean_distance, input ready);
  modport sink   (input valid, speed_one, speed_two, distance_one, distance_two,
                  mean_distance, output ready);
endinterface

// ===== rtl/core/dual_quadrature_odometer_unit.sv =====
// A tick's result passes through the tick queue and the back-end states SPEED, STEP, ACC and EMIT.
// Throughput: one encoder sample per cycle; any sample, tick or not, stalls while the queue is full.
// Ticks are processed one at a time by the back-end sequencer; a 4-entry queue absorbs
// bursts and in_ch.ready drops only while that queue is full.
// Reset (rst_n low, synchronous): levels, edge counts, distances, queue and output valid cleared;
// speed_scale and sample_period return to 65536 and 655.
// ----------------------------------------------------------------------------
// dual_quadrature_odometer_unit
// Two x4 quadrature decoders with speed and distance integration per tick.
// ----------------------------------------------------------------------------
`include "dual_quadrature_odometer_unit_macros.svh"

module dual_quadrature_odometer_unit #(
  parameter int COUNT_WIDTH = qod_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  qod_in_if.sink                             in_ch,
  qod_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [qod_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qod_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [qod_pkg::SCALE_W-1:0]  speed_scale_r;
  logic [qod_pkg::PERIOD_W-1:0] sample_period_r;

  logic                   push, pop, pop_valid, back_busy;
  qod_pkg::tick_entry_t   push_entry, pop_entry;
  qod_pkg::queue_status_t q_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_scale_r   <= qod_pkg::SCALE_RESET;
      sample_period_r <= qod_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      case (qod_pkg::cfg_idx_t'(cfg_index))
        qod_pkg::CFG_SPEED_SCALE:   speed_scale_r   <= cfg_wdata[qod_pkg::SCALE_W-1:0];
        qod_pkg::CFG_SAMPLE_PERIOD: sample_period_r <= cfg_wdata[qod_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  qod_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .line_a      (in_ch.line_a),
    .line_b      (in_ch.line_b),
    .line_c      (in_ch.line_c),
    .line_d      (in_ch.line_d),
    .sample_tick (in_ch.sample_tick),
    .q_status    (q_status),
    .push        (push),
    .push_entry  (push_entry)
  );

  qod_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .status     (q_status)
  );

  qod_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_entry     (pop_entry),
    .pop           (pop),
    .speed_scale   (speed_scale_r),
    .sample_period (sample_period_r),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .speed_one     (out_ch.speed_one),
    .speed_two     (out_ch.speed_two),
    .distance_one  (out_ch.distance_one),
    .distance_two  (out_ch.distance_two),
    .mean_distance (out_ch.mean_distance),
    .busy          (back_busy)
  );

  // a full queue must hold off the encoder stream
  `QOD_ASSERT_IMP(a_full_stalls, q_status.full, !in_ch.ready, "queue full but input ready")
  // an accepted tick is either queued or already in the back end
  `QOD_ASSERT_NXT(a_tick_kept, in_ch.valid && in_ch.ready && in_ch.sample_tick, q_status.count != 0 || back_busy, "tick transaction lost")
  // results only appear out of the back-end sequence
  `QOD_ASSERT_IMP(a_out_from_back, $rose(out_ch.valid), $past(back_busy), "result without back-end work")

endmodule

// ===== rtl/core/qod_front.sv =====
// ----------------------------------------------------------------------------
// qod_front
// x4 edge decoding of both encoders; latches and clears counts on a tick.
// ----------------------------------------------------------------------------
module qod_front #(
  parameter int COUNT_WIDTH = qod_pkg::COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  line_a,
  input  logic                  line_b,
  input  logic                  line_c,
  input  logic                  line_d,
  input  logic                  sample_tick,
  input  qod_pkg::queue_status_t q_status,
  output logic                  push,
  output qod_pkg::tick_entry_t  push_entry
);

  localparam int EXT_W = (COUNT_WIDTH > qod_pkg::LATCH_W) ? COUNT_WIDTH : qod_pkg::LATCH_W;

  logic [3:0]             prev_r, prev_nxt;
  logic [COUNT_WIDTH-1:0] cnt_one_r, cnt_one_nxt, sum_one;
  logic [COUNT_WIDTH-1:0] cnt_two_r, cnt_two_nxt, sum_two;
  logic [EXT_W-1:0]       ext_one, ext_two;
  logic                   accept;

  // -1, 0 or +1 per line, both lines may move at once
  function automatic logic signed [2:0] edge_delta(input logic pa, input logic pb,
                                                   input logic a, input logic b);
    logic signed [2:0] d;
    d = 3'sd0;
    if (pa != a) d = d + ((a != b) ? 3'sd1 : -3'sd1);
    if (pb != b) d = d + ((a == b) ? 3'sd1 : -3'sd1);
    return d;
  endfunction

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && sample_tick;

  always_comb begin
    logic signed [2:0] d1, d2;
    d1 = edge_delta(prev_r[0], prev_r[1], line_a, line_b);
    d2 = edge_delta(prev_r[2], prev_r[3], line_c, line_d);
    sum_one = cnt_one_r + {{(COUNT_WIDTH-3){d1[2]}}, d1};
    sum_two = cnt_two_r + {{(COUNT_WIDTH-3){d2[2]}}, d2};

    prev_nxt    = prev_r;
    cnt_one_nxt = cnt_one_r;
    cnt_two_nxt = cnt_two_r;
    if (accept) begin
      prev_nxt = {line_d, line_c, line_b, line_a};
      if (sample_tick) begin
        cnt_one_nxt = '0;
        cnt_two_nxt = '0;
      end else begin
        cnt_one_nxt = sum_one;
        cnt_two_nxt = sum_two;
      end
    end
  end

  // sign-extend from the counter width, then keep the low 16 bits
  assign ext_one = EXT_W'($signed(sum_one));
  assign ext_two = EXT_W'($signed(sum_two));
  assign push_entry.count_one = ext_one[qod_pkg::LATCH_W-1:0];
  assign push_entry.count_two = ext_two[qod_pkg::LATCH_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      cnt_one_r <= '0;
      cnt_two_r <= '0;
    end else begin
      prev_r    <= prev_nxt;
      cnt_one_r <= cnt_one_nxt;
      cnt_two_r <= cnt_two_nxt;
    end
  end

endmodule

// ===== rtl/core/qod_queue.sv =====
// ----------------------------------------------------------------------------
// qod_queue
// Short FIFO of latched tick counts between the front end and the back end.
// ----------------------------------------------------------------------------
module qod_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  qod_pkg::tick_entry_t   push_entry,
  input  logic                   pop,
  output logic                   pop_valid,
  output qod_pkg::tick_entry_t   pop_entry,
  output qod_pkg::queue_status_t status
);

  qod_pkg::tick_entry_t            entries_r [qod_pkg::QUEUE_DEPTH];
  logic [qod_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [qod_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [qod_pkg::QPTR_W:0]        count_r, count_nxt;
  logic                            do_push, do_pop;

  assign status.full  = (count_r == (qod_pkg::QPTR_W+1)'(qod_pkg::QUEUE_DEPTH));
  assign status.count = count_r;
  assign pop_valid    = (count_r != '0);
  assign pop_entry    = entries_r[rd_ptr_r];

  assign do_push = push && !status.full;
  assign do_pop  = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/qod_back.sv =====
// ----------------------------------------------------------------------------
// qod_back
// Scales latched counts to speeds, integrates distances, registers results.
// ----------------------------------------------------------------------------
module qod_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                pop_valid,
  input  qod_pkg::tick_entry_t                pop_entry,
  output logic                                pop,
  input  logic [qod_pkg::SCALE_W-1:0]         speed_scale,
  input  logic [qod_pkg::PERIOD_W-1:0]        sample_period,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [qod_pkg::SPEED_W-1:0] speed_one,
  output logic signed [qod_pkg::SPEED_W-1:0] speed_two,
  output logic signed [qod_pkg::DIST_W-1:0]  distance_one,
  output logic signed [qod_pkg::DIST_W-1:0]  distance_two,
  output logic signed [qod_pkg::DIST_W-1:0]  mean_distance,
  output logic                                busy
);

  localparam int SW = qod_pkg::SPEED_W;
  localparam int DW = qod_pkg::DIST_W;
  localparam int LW = qod_pkg::LATCH_W;
  localparam int MP = qod_pkg::LATCH_W + 1 + qod_pkg::SCALE_W + 1;   // count * scale
  localparam int PP = qod_pkg::SPEED_W + qod_pkg::PERIOD_W + 1;      // speed * period
  localparam int FRAC = 16;

  qod_pkg::back_state_t   state_r, state_nxt;
  qod_pkg::tick_entry_t   cnt_r;
  logic signed [SW-1:0]   sp_one_r, sp_two_r;
  logic signed [DW-1:0]   step_one_r, step_two_r;
  logic signed [DW-1:0]   travel_one_r, travel_two_r;
  logic                   out_valid_r;
  logic signed [SW-1:0]   out_sp_one_r, out_sp_two_r;
  logic signed [DW-1:0]   out_d_one_r, out_d_two_r, out_mean_r;

  logic signed [LW:0]     neg_one, pos_two;
  logic signed [MP-1:0]   prod_one, prod_two;
  logic signed [PP-1:0]   dp_one, dp_two;
  logic signed [DW:0]     sum;
  logic                   out_free;

  assign busy     = (state_r != qod_pkg::BK_IDLE);
  assign pop      = (state_r == qod_pkg::BK_IDLE) && pop_valid;
  assign out_free = !out_valid_r || out_ready;

  // motor 1 is negated
  assign neg_one  = -$signed({cnt_r.count_one[LW-1], cnt_r.count_one});
  assign pos_two  = $signed({cnt_r.count_two[LW-1], cnt_r.count_two});
  assign prod_one = neg_one * $signed({1'b0, speed_scale});
  assign prod_two = pos_two * $signed({1'b0, speed_scale});

  // Q.32 product, round half up to Q.16
  assign dp_one = sp_one_r * $signed({1'b0, sample_period}) + PP'(32768);
  assign dp_two = sp_two_r * $signed({1'b0, sample_period}) + PP'(32768);

  assign sum = {travel_one_r[DW-1], travel_one_r} + {travel_two_r[DW-1], travel_two_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qod_pkg::BK_IDLE:  if (pop_valid) state_nxt = qod_pkg::BK_SPEED;
      qod_pkg::BK_SPEED: state_nxt = qod_pkg::BK_STEP;
      qod_pkg::BK_STEP:  state_nxt = qod_pkg::BK_ACC;
      qod_pkg::BK_ACC:   state_nxt = qod_pkg::BK_EMIT;
      qod_pkg::BK_EMIT:  if (out_free) state_nxt = qod_pkg::BK_IDLE;
      default:           state_nxt = qod_pkg::BK_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cnt_r <= pop_entry;
    end
    if (state_r == qod_pkg::BK_SPEED) begin
      sp_one_r <= prod_one[SW-1:0];
      sp_two_r <= prod_two[SW-1:0];
    end
    // step is signed, sign-extend into the accumulator width
    if (state_r == qod_pkg::BK_STEP) begin
      step_one_r <= DW'($signed(dp_one[PP-1:FRAC]));
      step_two_r <= DW'($signed(dp_two[PP-1:FRAC]));
    end
    if ((state_r == qod_pkg::BK_EMIT) && out_free) begin
      out_sp_one_r <= sp_one_r;
      out_sp_two_r <= sp_two_r;
      out_d_one_r  <= travel_one_r;
      out_d_two_r  <= travel_two_r;
      out_mean_r   <= sum[DW:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= qod_pkg::BK_IDLE;
      travel_one_r <= '0;
      travel_two_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == qod_pkg::BK_ACC) begin
        travel_one_r <= travel_one_r + step_one_r;
        travel_two_r <= travel_two_r + step_two_r;
      end
      if ((state_r == qod_pkg::BK_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign speed_one     = out_sp_one_r;
  assign speed_two     = out_sp_two_r;
  assign distance_one  = out_d_one_r;
  assign distance_two  = out_d_two_r;
  assign mean_distance = out_mean_r;

endmodule

// ===== tb/dual_quadrature_odometer_unit_test.sv =====
// ----------------------------------------------------------------------------
// dual_quadrature_odometer_unit_test
// Self-checking bench for the dual x4 quadrature odometer. Encoder samples are
// driven in random bursts with a stalling result sink. A scoreboard tracks edge
// counts, speeds and wrapping distances, and compares every odometry result.
// ----------------------------------------------------------------------------
module dual_quadrature_odometer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNT_W     = qod_pkg::COUNT_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 12;

  typedef struct packed {
    bit line_a;
    bit line_b;
    bit line_c;
    bit line_d;
    bit sample_tick;
  } encoder_sample_t;

  typedef struct packed {
    logic signed [qod_pkg::SPEED_W-1:0] speed_one;
    logic signed [qod_pkg::SPEED_W-1:0] speed_two;
    logic signed [qod_pkg::DIST_W-1:0]  distance_one;
    logic signed [qod_pkg::DIST_W-1:0]  distance_two;
    logic signed [qod_pkg::DIST_W-1:0]  mean_distance;
  } odometry_t;

  class odometry_scoreboard;
    bit [qod_pkg::SCALE_W-1:0]  speed_scale;
    bit [qod_pkg::PERIOD_W-1:0] sample_period;
    bit [3:0]                   prev_levels;
    bit [COUNT_W-1:0]           count_one;
    bit [COUNT_W-1:0]           count_two;
    bit [qod_pkg::DIST_W-1:0]   travel_one;
    bit [qod_pkg::DIST_W-1:0]   travel_two;
    odometry_t                  expected_odometry[$];
    int                         mismatches;

    function new();
      speed_scale   = qod_pkg::SCALE_RESET;
      sample_period = qod_pkg::PERIOD_RESET;
      prev_levels   = '0;
      count_one     = '0;
      count_two     = '0;
      travel_one    = '0;
      travel_two    = '0;
      mismatches    = 0;
    endfunction

    function void set_rates(bit [qod_pkg::SCALE_W-1:0] scale,
                            bit [qod_pkg::PERIOD_W-1:0] period);
      speed_scale   = scale;
      sample_period = period;
    endfunction

    function int outstanding();
      return expected_odometry.size();
    endfunction

    // x4 decode of one A/B pair
    function bit [COUNT_W-1:0] count_edges(bit [COUNT_W-1:0] cnt, bit pa, bit pb,
                                           bit a, bit b);
      bit [COUNT_W-1:0] n;
      n = cnt;
      if (pa != a) n = (a != b) ? n + 1'b1 : n - 1'b1;
      if (pb != b) n = (a == b) ? n + 1'b1 : n - 1'b1;
      return n;
    endfunction

    // counter read as a 16-bit signed count
    function longint latch_count(bit [COUNT_W-1:0] cnt);
      longint  wide;
      shortint c16;
      wide = longint'(signed'(cnt));
      c16  = wide[15:0];
      return c16;
    endfunction

    // Q.32 product rounded half up to Q.16
    function longint travel_step(longint speed);
      return (speed * longint'(sample_period) + 64'sd32768) >>> 16;
    endfunction

    function void note_sample(encoder_sample_t s);
      longint    s1;
      longint    s2;
      longint    step;
      longint    sum;
      odometry_t r;
      count_one = count_edges(count_one, prev_levels[0], prev_levels[1],
                              s.line_a, s.line_b);
      count_two = count_edges(count_two, prev_levels[2], prev_levels[3],
                              s.line_c, s.line_d);
      prev_levels = {s.line_d, s.line_c, s.line_b, s.line_a};
      if (!s.sample_tick) return;
      s1 = -(latch_count(count_one) * longint'(speed_scale));
      s2 = latch_count(count_two) * longint'(speed_scale);
      count_one = '0;
      count_two = '0;
      step = travel_step(s1);
      travel_one = travel_one + step[qod_pkg::DIST_W-1:0];
      step = travel_step(s2);
      travel_two = travel_two + step[qod_pkg::DIST_W-1:0];
      sum = longint'(signed'(travel_one)) + longint'(signed'(travel_two));
      r.speed_one     = s1[qod_pkg::SPEED_W-1:0];
      r.speed_two     = s2[qod_pkg::SPEED_W-1:0];
      r.distance_one  = travel_one;
      r.distance_two  = travel_two;
      r.mean_distance = sum[qod_pkg::DIST_W:1];   // floor of the halved sum
      expected_odometry.push_back(r);
    endfunction

    function void check_result(odometry_t got);
      odometry_t exp_r;
      bit [4:0]  bad;
      if (expected_odometry.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: speed %0d/%0d dist %0d/%0d mean %0d",
                   $realtime, got.speed_one, got.speed_two, got.distance_one,
                   got.distance_two, got.mean_distance);
        return;
      end
      exp_r = expected_odometry.pop_front();
      bad[0] = got.speed_one     !== exp_r.speed_one;
      bad[1] = got.speed_two     !== exp_r.speed_two;
      bad[2] = got.distance_one  !== exp_r.distance_one;
      bad[3] = got.distance_two  !== exp_r.distance_two;
      bad[4] = got.mean_distance !== exp_r.mean_distance;
      if (|bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: odometry mismatch, fields (mean,d2,d1,s2,s1) = %b", $realtime, bad);
          $display("  expected speed %0d/%0d dist %0d/%0d mean %0d",
                   exp_r.speed_one, exp_r.speed_two, exp_r.distance_one,
                   exp_r.distance_two, exp_r.mean_distance);
          $display("  actual   speed %0d/%0d dist %0d/%0d mean %0d",
                   got.speed_one, got.speed_two, got.distance_one,
                   got.distance_two, got.mean_distance);
        end
      end
    endfunction
  endclass

  bit clk = 1'b0;
  logic rst_n;
  logic                           cfg_we;
  logic [qod_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [qod_pkg::CFG_DATA_W-1:0] cfg_wdata;

  qod_in_if  in_ch();
  qod_out_if out_ch();

  dual_quadrature_odometer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  odometry_scoreboard tracker = new();

  int cycles     = 0;
  int burst_left = 0;
  bit gapless    = 1'b0;
  bit hold_req   = 1'b0;
  int enc_ph[2];
  int enc_dir[2] = '{1, -1};

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("dual_quadrature_odometer_unit test failed");
      $finish;
    end
  end

  // gray phase 0..3 to {b, a}
  function automatic bit [1:0] phase_levels(int ph);
    return {ph == 2 || ph == 3, ph == 1 || ph == 2};
  endfunction

  task automatic send_sample(encoder_sample_t s);
    int gap;
    if (burst_left == 0) begin
      if (!gapless) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left = $urandom_range(1, 16);
    end
    in_ch.valid       <= 1'b1;
    in_ch.line_a      <= s.line_a;
    in_ch.line_b      <= s.line_b;
    in_ch.line_c      <= s.line_c;
    in_ch.line_d      <= s.line_d;
    in_ch.sample_tick <= s.sample_tick;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_sample(s);
    burst_left--;
  endtask

  // all results in, then let the back end settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_rates(bit [qod_pkg::SCALE_W-1:0] scale,
                           bit [qod_pkg::PERIOD_W-1:0] period);
    cfg_we    <= 1'b1;
    cfg_index <= qod_pkg::CFG_SPEED_SCALE;
    cfg_wdata <= scale;
    @(posedge clk);
    cfg_index <= qod_pkg::CFG_SAMPLE_PERIOD;
    cfg_wdata <= qod_pkg::CFG_DATA_W'(period);
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_rates(scale, period);
  endtask

  task automatic run_directed();
    // {tick, d, c, b, a}
    bit [4:0] seq [0:12];
    encoder_sample_t s;
    seq = '{5'b11101,   // edges from the zero reset levels, ticked at once
            5'b11101,   // tick with no movement
            5'b01111,   // encoder 1 B edge, up
            5'b01010,   // A and C both change, up
            5'b10000,   // B and D both change, up, counted on this tick
            5'b01111,   // both lines of each pair together
            5'b00000,   // and back
            5'b01010,   // backwards
            5'b01111,
            5'b10101,
            5'b11010,   // both lines together on a tick
            5'b00011,
            5'b10011};
    foreach (seq[i]) begin
      s = '{seq[i][0], seq[i][1], seq[i][2], seq[i][3], seq[i][4]};
      send_sample(s);
    end
    enc_ph = '{2, 0};
  endtask

  // mostly clean rotation, with direction reversals and random jumps
  task automatic run_random(int n, int tick_div);
    encoder_sample_t s;
    bit [1:0] lv [2];
    int r;
    repeat (n) begin
      for (int e = 0; e < 2; e++) begin
        r = $urandom_range(0, 99);
        if (r < 5) enc_dir[e] = -enc_dir[e];
        if (r < 70) enc_ph[e] = (enc_ph[e] + enc_dir[e]) & 3;
        else if (r >= 90) enc_ph[e] = $urandom_range(0, 3);
        lv[e] = phase_levels(enc_ph[e]);
      end
      s = '{lv[0][0], lv[0][1], lv[1][0], lv[1][1], $urandom_range(0, tick_div - 1) == 0};
      send_sample(s);
    end
  endtask

  // steady runs ticked only on their last sample, one encoder up and the other down
  task automatic spin(int up_one, int down_two);
    encoder_sample_t s;
    bit [1:0] lv [2];
    int n;
    n = (up_one > down_two) ? up_one : down_two;
    for (int i = 0; i < n; i++) begin
      if (i < up_one) enc_ph[0] = (enc_ph[0] + 1) & 3;
      if (i < down_two) enc_ph[1] = (enc_ph[1] - 1) & 3;
      lv[0] = phase_levels(enc_ph[0]);
      lv[1] = phase_levels(enc_ph[1]);
      s = '{lv[0][0], lv[0][1], lv[1][0], lv[1][1], i == n - 1};
      send_sample(s);
    end
  endtask

  // result sink: own stall pattern, plus one long hold-off on request
  initial begin
    int hold_left;
    int pattern_age;
    int stall_mode;
    odometry_t got;
    hold_left   = 0;
    pattern_age = 0;
    stall_mode  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.speed_one     = out_ch.speed_one;
        got.speed_two     = out_ch.speed_two;
        got.distance_one  = out_ch.distance_one;
        got.distance_two  = out_ch.distance_two;
        got.mean_distance = out_ch.mean_distance;
        tracker.check_result(got);
      end
      if (pattern_age == 0) begin
        stall_mode  = $urandom_range(0, 3);
        pattern_age = $urandom_range(16, 96);
      end
      pattern_age--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
        out_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= $urandom_range(0, 3) != 0;
          2:       out_ch.ready <= $urandom_range(0, 3) == 0;
          default: out_ch.ready <= ~out_ch.ready;
        endcase
      end
    end
  end

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= qod_pkg::CFG_SPEED_SCALE;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.line_a      <= 1'b0;
    in_ch.line_b      <= 1'b0;
    in_ch.line_c      <= 1'b0;
    in_ch.line_d      <= 1'b0;
    in_ch.sample_tick <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset rates
    run_directed();
    run_random(150, 20);
    drain();

    // largest rates, a steady run ticked only at its end
    set_rates('1, '1);
    gapless = 1'b1;
    spin(40, 52);
    gapless = 1'b0;
    run_random(150, 20);
    drain();

    set_rates('0, '1);
    run_random(100, 10);
    drain();

    set_rates('1, '0);
    run_random(100, 10);
    drain();

    // sink held off while ticks keep coming: the tick queue fills up
    set_rates(qod_pkg::SCALE_W'($urandom_range(0, 24'hFFFFFF)),
              qod_pkg::PERIOD_W'($urandom_range(0, 16'hFFFF)));
    hold_req = 1'b1;
    gapless  = 1'b1;
    run_random(150, 2);
    gapless  = 1'b0;
    drain();

    for (int k = 0; k < 4; k++) begin
      if (k == 0) set_rates(qod_pkg::SCALE_W'($urandom_range(0, 255)),
                            qod_pkg::PERIOD_W'($urandom_range(0, 255)));
      else set_rates(qod_pkg::SCALE_W'($urandom_range(0, 24'hFFFFFF)),
                     qod_pkg::PERIOD_W'($urandom_range(0, 16'hFFFF)));
      gapless = (k == 2);
      run_random(165, 16);
      drain();
    end

    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("dual_quadrature_odometer_unit test passed");
    end else begin
      $display("dual_quadrature_odometer_unit test failed");
    end
    $finish;
  end

endmodule
